// ===== hdl/cpualu_pkg.sv =====
// cpualu_pkg: operation codes, flag and item types for the 8-bit alu
// with flag register; used by cpualu_core and cpu_alu_with_flags
// no dependencies
package cpualu_pkg;

  localparam int unsigned WordW   = 16;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned ActionW = 5;
  localparam int unsigned BitIdxW = 3;

  // operation codes
  typedef enum logic [ActionW-1:0] {
    ACT_INC     = 5'd0,
    ACT_DEC     = 5'd1,
    ACT_ADD     = 5'd2,
    ACT_ADC     = 5'd3,
    ACT_SUB     = 5'd4,
    ACT_SBC     = 5'd5,
    ACT_CP      = 5'd6,
    ACT_AND     = 5'd7,
    ACT_OR      = 5'd8,
    ACT_XOR     = 5'd9,
    ACT_BIT     = 5'd10,
    ACT_SWAP    = 5'd11,
    ACT_RLCA    = 5'd12,
    ACT_RLC     = 5'd13,
    ACT_RLA     = 5'd14,
    ACT_RL      = 5'd15,
    ACT_RRCA    = 5'd16,
    ACT_RRC     = 5'd17,
    ACT_RRA     = 5'd18,
    ACT_RR      = 5'd19,
    ACT_SLA     = 5'd20,
    ACT_SRA     = 5'd21,
    ACT_SRL     = 5'd22,
    ACT_ADD16   = 5'd23,
    ACT_ADD_SP  = 5'd24,
    ACT_LD_FLAG = 5'd25
  } action_t;

  // flag register, z in the top bit as in the flag byte
  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  // one input item as held in the input register
  typedef struct packed {
    logic [ActionW-1:0] action;
    logic [WordW-1:0]   operand_a;
    logic [WordW-1:0]   operand_b;
    logic [BitIdxW-1:0] bit_index;
    logic               carry_in;
  } item_t;

  // one result item
  typedef struct packed {
    logic [WordW-1:0] result;
    flags_t           flags;
  } res_t;

endpackage

// ===== hdl/cpualu_core.sv =====
// cpualu_core: combinational datapath for one alu operation and its flags
// depends on cpualu_pkg
module cpualu_core (
  input  cpualu_pkg::item_t  item,
  input  cpualu_pkg::flags_t flags_cur,
  output cpualu_pkg::res_t   res
);

  logic [7:0]  a;
  logic [7:0]  b;
  logic [15:0] a16;
  logic [15:0] b16;
  logic        cin_add;
  logic        cin_sub;
  logic [8:0]  sum9;
  logic [4:0]  hsum5;
  logic [8:0]  dif9;
  logic [4:0]  hdif5;
  logic [16:0] sum17;
  logic [12:0] sum13;
  logic [15:0] sp_sum;
  logic [4:0]  sp_h5;
  logic [8:0]  sp_c9;
  logic [7:0]  r8;
  logic [15:0] r16;
  logic        wide;
  cpualu_pkg::flags_t f;

  assign a   = item.operand_a[7:0];
  assign b   = item.operand_b[7:0];
  assign a16 = item.operand_a;
  assign b16 = item.operand_b;

  // carry/borrow only enters for adc and sbc
  assign cin_add = (item.action == cpualu_pkg::ACT_ADC) ? item.carry_in : 1'b0;
  assign cin_sub = (item.action == cpualu_pkg::ACT_SBC) ? item.carry_in : 1'b0;

  // 8-bit adder and subtractor with nibble carries
  assign sum9  = {1'b0, a} + {1'b0, b} + {8'd0, cin_add};
  assign hsum5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin_add};
  assign dif9  = {1'b0, a} - {1'b0, b} - {8'd0, cin_sub};
  assign hdif5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin_sub};

  // 16-bit add, carries from bit 11 and bit 15
  assign sum17 = {1'b0, a16} + {1'b0, b16};
  assign sum13 = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};

  // word plus signed byte, flags from the unsigned low byte add
  assign sp_sum = a16 + {{8{b[7]}}, b};
  assign sp_h5  = {1'b0, a16[3:0]} + {1'b0, b[3:0]};
  assign sp_c9  = {1'b0, a16[7:0]} + {1'b0, b};

  // operation decode
  always_comb begin
    r8   = 8'd0;
    r16  = 16'd0;
    wide = 1'b0;
    f    = flags_cur;
    unique case (item.action) inside
      cpualu_pkg::ACT_INC: begin
        r8  = a + 8'd1;
        f.z = (r8 == 8'd0);
        f.n = 1'b0;
        f.h = (a[3:0] == 4'hF);
      end
      cpualu_pkg::ACT_DEC: begin
        r8  = a - 8'd1;
        f.z = (r8 == 8'd0);
        f.n = 1'b1;
        f.h = (a[3:0] == 4'h0);
      end
      cpualu_pkg::ACT_ADD, cpualu_pkg::ACT_ADC: begin
        r8 = sum9[7:0];
        f  = '{z: (sum9[7:0] == 8'd0), n: 1'b0, h: hsum5[4], c: sum9[8]};
      end
      cpualu_pkg::ACT_SUB, cpualu_pkg::ACT_SBC: begin
        r8 = dif9[7:0];
        f  = '{z: (dif9[7:0] == 8'd0), n: 1'b1, h: hdif5[4], c: dif9[8]};
      end
      cpualu_pkg::ACT_CP: begin
        r8 = a;
        f  = '{z: (dif9[7:0] == 8'd0), n: 1'b1, h: hdif5[4], c: dif9[8]};
      end
      cpualu_pkg::ACT_AND: begin
        r8 = a & b;
        f  = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
      end
      cpualu_pkg::ACT_OR: begin
        r8 = a | b;
        f  = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      cpualu_pkg::ACT_XOR: begin
        r8 = a ^ b;
        f  = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      cpualu_pkg::ACT_BIT: begin
        r8  = a;
        f.z = ~a[item.bit_index];
        f.n = 1'b0;
        f.h = 1'b1;
      end
      cpualu_pkg::ACT_SWAP: begin
        r8 = {a[3:0], a[7:4]};
        f  = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      cpualu_pkg::ACT_RLCA, cpualu_pkg::ACT_RLC: begin
        r8 = {a[6:0], a[7]};
        f  = '{z: item.action[0] & (r8 == 8'd0), n: 1'b0, h: 1'b0, c: a[7]};
      end
      cpualu_pkg::ACT_RLA, cpualu_pkg::ACT_RL: begin
        r8 = {a[6:0], flags_cur.c};
        f  = '{z: item.action[0] & (r8 == 8'd0), n: 1'b0, h: 1'b0, c: a[7]};
      end
      cpualu_pkg::ACT_RRCA, cpualu_pkg::ACT_RRC: begin
        r8 = {a[0], a[7:1]};
        f  = '{z: item.action[0] & (r8 == 8'd0), n: 1'b0, h: 1'b0, c: a[0]};
      end
      cpualu_pkg::ACT_RRA, cpualu_pkg::ACT_RR: begin
        r8 = {flags_cur.c, a[7:1]};
        f  = '{z: item.action[0] & (r8 == 8'd0), n: 1'b0, h: 1'b0, c: a[0]};
      end
      cpualu_pkg::ACT_SLA: begin
        r8 = {a[6:0], 1'b0};
        f  = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: a[7]};
      end
      cpualu_pkg::ACT_SRA: begin
        r8 = {a[7], a[7:1]};
        f  = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: a[0]};
      end
      cpualu_pkg::ACT_SRL: begin
        r8 = {1'b0, a[7:1]};
        f  = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: a[0]};
      end
      cpualu_pkg::ACT_ADD16: begin
        wide = 1'b1;
        r16  = sum17[15:0];
        f.n  = 1'b0;
        f.h  = sum13[12];
        f.c  = sum17[16];
      end
      cpualu_pkg::ACT_ADD_SP: begin
        wide = 1'b1;
        r16  = sp_sum;
        f    = '{z: 1'b0, n: 1'b0, h: sp_h5[4], c: sp_c9[8]};
      end
      cpualu_pkg::ACT_LD_FLAG: begin
        r8 = {b[7:4], 4'h0};
        f  = '{z: b[7], n: b[6], h: b[5], c: b[4]};
      end
      default: begin
        // undefined codes: zero result, flags kept
        r8 = 8'd0;
      end
    endcase
  end

  assign res.result = wide ? r16 : {8'd0, r8};
  assign res.flags  = f;

endmodule

// ===== hdl/cpu_alu_with_flags.sv =====
// cpu_alu_with_flags: top level with input register, flag register and
// result register around the alu datapath
// depends on cpualu_pkg and cpualu_core
//
// 8-bit processor alu with a zero/subtract/half-carry/carry flag register.
// One transfer is taken per clock cycle on the input channel and one result
// leaves per cycle on the output channel while the output does not stall. A
// result passes from the input register through the datapath into the result
// register. The flag register is read and written in that single datapath
// pass, so each operation sees the flags left by the one before it. The input
// register keeps accepting while an earlier result waits, and stalls only
// when both registers are full and the output stalls.
module cpu_alu_with_flags (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [4:0]  action,
  input  logic [15:0] operand_a,
  input  logic [15:0] operand_b,
  input  logic [2:0]  bit_index,
  input  logic        carry_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] result,
  output logic        zero_flag,
  output logic        subtract_flag,
  output logic        half_carry_flag,
  output logic        carry_flag
);

  logic                s1_valid;
  cpualu_pkg::item_t   s1_item;
  cpualu_pkg::flags_t  flag_bits;
  cpualu_pkg::res_t    core_res;
  logic [15:0]         result_reg;
  logic                in_xfer;
  logic                advance;

  // handshake: result register frees when empty or taken
  assign advance  = s1_valid & (~out_valid | ~out_stall);
  assign in_stall = s1_valid & ~advance;
  assign in_xfer  = in_valid & ~in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item <= '{action: action, operand_a: operand_a, operand_b: operand_b,
                   bit_index: bit_index, carry_in: carry_in};
    end
  end

  // datapath
  cpualu_core u_core (
    .item      (s1_item),
    .flags_cur (flag_bits),
    .res       (core_res)
  );

  // flag register and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      flag_bits <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      flag_bits <= core_res.flags;
      out_valid <= 1'b1;
    end else if (~out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (advance) begin
      result_reg <= core_res.result;
    end
  end

  // the flag register always holds the flags of the last result
  assign result          = result_reg;
  assign zero_flag       = flag_bits.z;
  assign subtract_flag   = flag_bits.n;
  assign half_carry_flag = flag_bits.h;
  assign carry_flag      = flag_bits.c;

endmodule

// ===== hdl/cpualu_checker.sv =====
// cpualu_checker: port-level assertions for cpu_alu_with_flags and the
// bind that attaches them; depends on the top level's port list only
module cpualu_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] result,
  input logic        zero_flag,
  input logic        subtract_flag,
  input logic        half_carry_flag,
  input logic        carry_flag
);

  // reset empties the result register
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // input stalls only when a full result register is held by the output
  assert property (@(posedge clk) disable iff (rst) in_stall |-> (out_valid && out_stall))
    else $error("input stalled with output free");

  // a stalled result stays offered
  assert property (@(posedge clk) disable iff (rst) (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");

  // a stalled result and its flags hold
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> ($stable(result) && $stable(zero_flag) &&
      $stable(subtract_flag) && $stable(half_carry_flag) && $stable(carry_flag)))
    else $error("stalled result changed");

endmodule

bind cpu_alu_with_flags cpualu_checker u_cpualu_checker (
  .clk             (clk),
  .rst             (rst),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .result          (result),
  .zero_flag       (zero_flag),
  .subtract_flag   (subtract_flag),
  .half_carry_flag (half_carry_flag),
  .carry_flag      (carry_flag)
);

// ===== tb/tb_cpu_alu_with_flags.sv =====
// tb_cpu_alu_with_flags: self-checking testbench for the 8-bit alu with flag register
// depends on cpualu_pkg and cpu_alu_with_flags; predicts every result and flag
// set in order and checks them against the output channel under random idling
module tb_cpu_alu_with_flags;

  localparam logic [cpualu_pkg::ActionW-1:0] ActFirstUnused = 5'd26;
  localparam logic [cpualu_pkg::ActionW-1:0] ActLastUnused  = 5'd31;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned TailCycles  = 8;
  localparam int unsigned RandomItems = 650;

  // one queued operation; settle holds it back until all results are in
  typedef struct {
    cpualu_pkg::item_t op;
    bit                settle;
  } send_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [4:0]  action = '0;
  logic [15:0] operand_a = '0;
  logic [15:0] operand_b = '0;
  logic [2:0]  bit_index = '0;
  logic        carry_in = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] result;
  logic        zero_flag;
  logic        subtract_flag;
  logic        half_carry_flag;
  logic        carry_flag;

  send_t                op_queue[$];
  cpualu_pkg::res_t     awaited_results[$];
  cpualu_pkg::flags_t   flag_model;
  cpualu_pkg::item_t    cur_op;
  int unsigned idle_left;
  int unsigned stall_left;
  int unsigned errors;
  int unsigned ops_sent;
  int unsigned results_checked;
  int unsigned cycles;
  bit          calm;

  cpu_alu_with_flags i_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .action          (action),
    .operand_a       (operand_a),
    .operand_b       (operand_b),
    .bit_index       (bit_index),
    .carry_in        (carry_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .result          (result),
    .zero_flag       (zero_flag),
    .subtract_flag   (subtract_flag),
    .half_carry_flag (half_carry_flag),
    .carry_flag      (carry_flag)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // alu behavior: applies one operation to the flag copy, returns result and flags
  function automatic cpualu_pkg::res_t alu_apply(cpualu_pkg::item_t it);
    logic [7:0]  a8;
    logic [7:0]  b8;
    logic [8:0]  sum9;
    logic [4:0]  nib;
    logic [12:0] sum13;
    logic [16:0] sum17;
    logic [15:0] r;
    logic        cin;
    logic        fill;
    cpualu_pkg::flags_t f;
    cpualu_pkg::res_t   o;
    a8   = it.operand_a[7:0];
    b8   = it.operand_b[7:0];
    f    = flag_model;
    r    = '0;
    cin  = 1'b0;
    fill = 1'b0;
    case (it.action)
      cpualu_pkg::ACT_INC: begin
        r   = {8'h00, a8 + 8'h01};
        f.z = (r[7:0] == 8'h00);
        f.n = 1'b0;
        f.h = (a8[3:0] == 4'hF);
      end
      cpualu_pkg::ACT_DEC: begin
        r   = {8'h00, a8 - 8'h01};
        f.z = (r[7:0] == 8'h00);
        f.n = 1'b1;
        f.h = (a8[3:0] == 4'h0);
      end
      cpualu_pkg::ACT_ADD, cpualu_pkg::ACT_ADC: begin
        cin  = (it.action == cpualu_pkg::ACT_ADC) ? it.carry_in : 1'b0;
        sum9 = {1'b0, a8} + {1'b0, b8} + cin;
        nib  = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + cin;
        r    = {8'h00, sum9[7:0]};
        f.z  = (sum9[7:0] == 8'h00);
        f.n  = 1'b0;
        f.h  = nib[4];
        f.c  = sum9[8];
      end
      cpualu_pkg::ACT_SUB, cpualu_pkg::ACT_SBC, cpualu_pkg::ACT_CP: begin
        // 9-bit and 5-bit differences, top bit set on borrow
        cin  = (it.action == cpualu_pkg::ACT_SBC) ? it.carry_in : 1'b0;
        sum9 = {1'b0, a8} - {1'b0, b8} - cin;
        nib  = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - cin;
        r    = (it.action == cpualu_pkg::ACT_CP) ? {8'h00, a8} : {8'h00, sum9[7:0]};
        f.z  = (sum9[7:0] == 8'h00);
        f.n  = 1'b1;
        f.h  = nib[4];
        f.c  = sum9[8];
      end
      cpualu_pkg::ACT_AND, cpualu_pkg::ACT_OR, cpualu_pkg::ACT_XOR: begin
        if (it.action == cpualu_pkg::ACT_AND) begin
          r = {8'h00, a8 & b8};
        end else if (it.action == cpualu_pkg::ACT_OR) begin
          r = {8'h00, a8 | b8};
        end else begin
          r = {8'h00, a8 ^ b8};
        end
        f.z = (r[7:0] == 8'h00);
        f.n = 1'b0;
        f.h = (it.action == cpualu_pkg::ACT_AND);
        f.c = 1'b0;
      end
      cpualu_pkg::ACT_BIT: begin
        r   = {8'h00, a8};
        f.z = ~a8[it.bit_index];
        f.n = 1'b0;
        f.h = 1'b1;
      end
      cpualu_pkg::ACT_SWAP: begin
        r = {8'h00, a8[3:0], a8[7:4]};
        f = '{z: (r[7:0] == 8'h00), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      cpualu_pkg::ACT_RLCA, cpualu_pkg::ACT_RLC,
      cpualu_pkg::ACT_RLA, cpualu_pkg::ACT_RL: begin
        fill = (it.action == cpualu_pkg::ACT_RLA || it.action == cpualu_pkg::ACT_RL)
               ? flag_model.c : a8[7];
        r    = {8'h00, a8[6:0], fill};
        f.z  = (it.action == cpualu_pkg::ACT_RLC || it.action == cpualu_pkg::ACT_RL)
               && (r[7:0] == 8'h00);
        f.n  = 1'b0;
        f.h  = 1'b0;
        f.c  = a8[7];
      end
      cpualu_pkg::ACT_RRCA, cpualu_pkg::ACT_RRC,
      cpualu_pkg::ACT_RRA, cpualu_pkg::ACT_RR: begin
        fill = (it.action == cpualu_pkg::ACT_RRA || it.action == cpualu_pkg::ACT_RR)
               ? flag_model.c : a8[0];
        r    = {8'h00, fill, a8[7:1]};
        f.z  = (it.action == cpualu_pkg::ACT_RRC || it.action == cpualu_pkg::ACT_RR)
               && (r[7:0] == 8'h00);
        f.n  = 1'b0;
        f.h  = 1'b0;
        f.c  = a8[0];
      end
      cpualu_pkg::ACT_SLA, cpualu_pkg::ACT_SRA, cpualu_pkg::ACT_SRL: begin
        if (it.action == cpualu_pkg::ACT_SLA) begin
          r = {8'h00, a8[6:0], 1'b0};
        end else if (it.action == cpualu_pkg::ACT_SRA) begin
          r = {8'h00, a8[7], a8[7:1]};
        end else begin
          r = {8'h00, 1'b0, a8[7:1]};
        end
        f.z = (r[7:0] == 8'h00);
        f.n = 1'b0;
        f.h = 1'b0;
        f.c = (it.action == cpualu_pkg::ACT_SLA) ? a8[7] : a8[0];
      end
      cpualu_pkg::ACT_ADD16: begin
        sum17 = {1'b0, it.operand_a} + {1'b0, it.operand_b};
        sum13 = {1'b0, it.operand_a[11:0]} + {1'b0, it.operand_b[11:0]};
        r     = sum17[15:0];
        f.n   = 1'b0;
        f.h   = sum13[12];
        f.c   = sum17[16];
      end
      cpualu_pkg::ACT_ADD_SP: begin
        // sign-extended byte for the sum, unsigned low byte for the flags
        r    = it.operand_a + {{8{b8[7]}}, b8};
        nib  = {1'b0, it.operand_a[3:0]} + {1'b0, b8[3:0]};
        sum9 = {1'b0, it.operand_a[7:0]} + {1'b0, b8};
        f    = '{z: 1'b0, n: 1'b0, h: nib[4], c: sum9[8]};
      end
      cpualu_pkg::ACT_LD_FLAG: begin
        r = {8'h00, it.operand_b[7:4], 4'h0};
        f = cpualu_pkg::flags_t'(it.operand_b[7:4]);
      end
      default: begin
        r = '0;
      end
    endcase
    flag_model = f;
    o.result   = r;
    o.flags    = f;
    return o;
  endfunction

  // idle length: mostly none or short, a few long, none in calm stretches
  function automatic int unsigned draw_gap();
    int unsigned pick;
    if (calm) begin
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      return 0;
    end else if (pick < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(6, 25);
  endfunction

  // operand with a bias toward edge values
  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h00FF;
      3: return 16'h0F0F;
      4: return {8'h00, 8'($urandom_range(0, 255))};
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_op(logic [4:0] act, logic [15:0] a, logic [15:0] b,
                          logic [2:0] bi, logic ci, bit settle);
    send_t s;
    s.op.action    = act;
    s.op.operand_a = a;
    s.op.operand_b = b;
    s.op.bit_index = bi;
    s.op.carry_in  = ci;
    s.settle       = settle;
    op_queue.push_back(s);
  endtask

  task automatic report_mismatch(string msg);
    errors++;
    $display("mismatch on result %0d: %s", results_checked, msg);
  endtask

  // cycle counter, calm stretches and timeout
  always @(posedge clk) begin
    cycles++;
    if (cycles % 128 == 0) begin
      calm <= ($urandom_range(0, 3) == 0);
    end
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, awaited_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // input driver: predicts on each transfer, then presents the next item
  always @(posedge clk) begin
    send_t nxt;
    if (rst) begin
      in_valid  <= 1'b0;
      idle_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        awaited_results.push_back(alu_apply(cur_op));
        ops_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (idle_left > 0) begin
          in_valid <= 1'b0;
          idle_left--;
        end else if (op_queue.size() == 0 ||
                     (op_queue[0].settle && awaited_results.size() != 0)) begin
          in_valid <= 1'b0;
        end else begin
          nxt       = op_queue.pop_front();
          cur_op    = nxt.op;
          action    <= cur_op.action;
          operand_a <= cur_op.operand_a;
          operand_b <= cur_op.operand_b;
          bit_index <= cur_op.bit_index;
          carry_in  <= cur_op.carry_in;
          in_valid  <= 1'b1;
          idle_left = draw_gap();
        end
      end
    end
  end

  // output monitor: checks each transfer and drives random stalls
  always @(posedge clk) begin
    cpualu_pkg::res_t want;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", result));
        end else begin
          want = awaited_results.pop_front();
          if (result !== want.result) begin
            report_mismatch($sformatf("result %h, expected %h", result, want.result));
          end
          if (zero_flag !== want.flags.z) begin
            report_mismatch($sformatf("zero flag %b, expected %b", zero_flag, want.flags.z));
          end
          if (subtract_flag !== want.flags.n) begin
            report_mismatch($sformatf("subtract flag %b, expected %b",
                                      subtract_flag, want.flags.n));
          end
          if (half_carry_flag !== want.flags.h) begin
            report_mismatch($sformatf("half carry flag %b, expected %b",
                                      half_carry_flag, want.flags.h));
          end
          if (carry_flag !== want.flags.c) begin
            report_mismatch($sformatf("carry flag %b, expected %b",
                                      carry_flag, want.flags.c));
          end
        end
        results_checked++;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall  <= 1'b0;
        stall_left = draw_gap();
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    logic [4:0] act;
    int unsigned pick;
    flag_model = '0;

    // directed: flag load first so that kept flags are visible
    queue_op(cpualu_pkg::ACT_LD_FLAG, 16'h0000, 16'hFFFF, 3'd0, 1'b0, 1'b0);
    queue_op(cpualu_pkg::ACT_INC,     16'h00FF, 16'h0000, 3'd0, 1'b0, 1'b0);
    queue_op(cpualu_pkg::ACT_DEC,     16'hFF00, 16'h0000, 3'd0, 1'b0, 1'b0);
    queue_op(cpualu_pkg::ACT_ADD,     16'h00FF, 16'h0001, 3'd0, 1'b0, 1'b0);
    queue_op(cpualu_pkg::ACT_ADC,     16'h000F, 16'h00F0, 3'd0, 1'b1, 1'b0);
    queue_op(cpualu_pkg::ACT_SUB,     16'h0000, 16'h00FF, 3'd0, 1'b0, 1'b0);
    queue_op(cpualu_pkg::ACT_SBC,     16'h0010, 16'h000F, 3'd0, 1'b1, 1'b0);
    queue_op(cpualu_pkg::ACT_SBC,     16'h00FF, 16'h00FF, 3'd0, 1'b1, 1'b0);
    queue_op(cpualu_pkg::ACT_CP,      16'hABCD, 16'h00CD, 3'd0, 1'b1, 1'b0);
    queue_op(cpualu_pkg::ACT_AND,     16'hFFFF, 16'h0000, 3'd0, 1'b0, 1'b0);
    queue_op(cpualu_pkg::ACT_OR,      16'h0000, 16'h0000, 3'd0, 1'b0, 1'b0);
    queue_op(cpualu_pkg::ACT_XOR,     16'hFFFF, 16'hFFFF, 3'd7, 1'b1, 1'b0);
    queue_op(cpualu_pkg::ACT_BIT,     16'h0080, 16'h0000, 3'd7, 1'b0, 1'b0);
    queue_op(cpualu_pkg::ACT_BIT,     16'hFF7F, 16'h0000, 3'd7, 1'b0, 1'b0);
    queue_op(cpualu_pkg::ACT_SWAP,    16'h00F0, 16'h0000, 3'd0, 1'b0, 1'b0);
    queue_op(cpualu_pkg::ACT_RLCA,    16'h0080, 16'h0000, 3'd0, 1'b0, 1'b0);
    queue_op(cpualu_pkg::ACT_RLC,     16'h0000, 16'h0000, 3'd0, 1'b0, 1'b0);
    queue_op(cpualu_pkg::ACT_RLA,     16'h0080, 16'h0000, 3'd0, 1'b0, 1'b0);
    queue_op(cpualu_pkg::ACT_RL,      16'h0080, 16'h0000, 3'd0, 1'b0, 1'b0);
    queue_op(cpualu_pkg::ACT_RRCA,    16'h0001, 16'h0000, 3'd0, 1'b0, 1'b0);
    queue_op(cpualu_pkg::ACT_RRC,     16'h0000, 16'h0000, 3'd0, 1'b0, 1'b0);
    queue_op(cpualu_pkg::ACT_RRA,     16'h0001, 16'h0000, 3'd0, 1'b0, 1'b0);
    queue_op(cpualu_pkg::ACT_RR,      16'h0001, 16'h0000, 3'd0, 1'b0, 1'b0);
    queue_op(cpualu_pkg::ACT_SLA,     16'h0080, 16'h0000, 3'd0, 1'b0, 1'b0);
    queue_op(cpualu_pkg::ACT_SRA,     16'h0081, 16'h0000, 3'd0, 1'b0, 1'b0);
    queue_op(cpualu_pkg::ACT_SRL,     16'h0001, 16'h0000, 3'd0, 1'b0, 1'b0);
    queue_op(cpualu_pkg::ACT_ADD16,   16'hFFFF, 16'h0001, 3'd0, 1'b0, 1'b0);
    queue_op(cpualu_pkg::ACT_ADD_SP,  16'hFFFF, 16'h0080, 3'd0, 1'b0, 1'b0);
    queue_op(ActLastUnused,           16'hFFFF, 16'hFFFF, 3'd7, 1'b1, 1'b0);

    // random operations, with a full drain at the start and midway
    for (int unsigned i = 0; i < RandomItems; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        act = 5'($urandom_range(ActFirstUnused, ActLastUnused));
      end else if (pick < 10) begin
        act = cpualu_pkg::ACT_LD_FLAG;
      end else begin
        act = 5'($urandom_range(cpualu_pkg::ACT_INC, cpualu_pkg::ACT_LD_FLAG));
      end
      queue_op(act, pick_word(), pick_word(), 3'($urandom_range(0, 7)),
               1'($urandom_range(0, 1)), (i == 0) || (i == RandomItems / 2));
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (op_queue.size() != 0 || in_valid) @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    $display("covered %0d operations (all codes, unused ones too) in %0d cycles",
             ops_sent, cycles);
    $display("checked %0d results with random gaps and stalls, %0d mismatches",
             results_checked, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
